/* hdl/pft_pkg.sv */
// Shared types and constants for the page frame table core.
// No dependencies; used by every module of the block.
package pft_pkg;

  localparam int ELEM_W         = 24;
  localparam int PAGE_SIZE      = 256;
  localparam int OFF_W          = $clog2(PAGE_SIZE);
  localparam int PAGE_BITS      = 16;
  localparam int CNT_W          = 32;
  localparam int NUM_FRAMES_DEF = 6;
  localparam int Q_DEPTH        = 2;

  localparam logic [CNT_W-1:0]     CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PAGE_BITS-1:0] LAST_INIT = PAGE_BITS'(1);

  // One classified request: page number and in-page offset.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [OFF_W-1:0]     offset;
  } req_t;

endpackage

/* hdl/pft_front.sv */
// Front end: takes requests, splits the index into page and offset.
// Depends on pft_pkg; feeds pft_queue.
module pft_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [pft_pkg::ELEM_W-1:0] in_element_index,
  input  logic                      q_ready,
  output logic                      q_push,
  output pft_pkg::req_t             q_data
);

  logic          front_vld_r;
  logic          front_vld_nxt;
  pft_pkg::req_t front_req_r;
  pft_pkg::req_t front_req_nxt;
  logic          accept;

  assign q_push = front_vld_r & q_ready;
  assign busy   = front_vld_r & ~q_ready;
  assign accept = start & ~busy;
  assign q_data = front_req_r;

  always_comb begin
    front_vld_nxt        = accept | (front_vld_r & ~q_push);
    front_req_nxt.page   = pft_pkg::PAGE_BITS'(in_element_index >> pft_pkg::OFF_W);
    front_req_nxt.offset = in_element_index[pft_pkg::OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else begin
      front_vld_r <= front_vld_nxt;
    end
  end

  // hold the payload unless a new request lands
  always_ff @(posedge clk) begin
    if (accept) begin
      front_req_r <= front_req_nxt;
    end
  end

endmodule

/* hdl/pft_queue.sv */
// Short request queue between front end and table back end.
// Depends on pft_pkg for the request type and depth.
module pft_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pft_pkg::req_t push_data,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output pft_pkg::req_t pop_data
);

  localparam int PW = (pft_pkg::Q_DEPTH > 1) ? $clog2(pft_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(pft_pkg::Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(pft_pkg::Q_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(pft_pkg::Q_DEPTH);

  pft_pkg::req_t   entry_r [pft_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign ready    = (count_r != CNT_FULL);
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push & ready;
  assign do_pop   = pop & valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/pft_back.sv */
// Back end: frame table, lookup, most-frequently-used victim choice, update.
// Depends on pft_pkg; pulls requests from pft_queue.
module pft_back #(
  parameter int NUM_FRAMES = pft_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  pft_pkg::req_t                      q_data,
  output logic                               q_pop,
  output logic                               out_strobe,
  output logic [$clog2(NUM_FRAMES)-1:0]      out_frame,
  output logic [pft_pkg::OFF_W-1:0]          out_offset,
  output logic                               out_hit,
  output logic                               out_writeback,
  output logic [pft_pkg::PAGE_BITS-1:0]      out_evicted_page
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int LV = FW;
  localparam int NP = 1 << LV;
  localparam int PB = pft_pkg::PAGE_BITS;
  localparam int CW = pft_pkg::CNT_W;

  typedef enum logic {S_LOOK, S_UPD} state_t;

  state_t           state_r;
  logic [PB-1:0]    page_r    [NUM_FRAMES];
  logic             valid_r   [NUM_FRAMES];
  logic [CW-1:0]    cnt_r     [NUM_FRAMES];
  logic [PB-1:0]    last_r;

  // lookup results held for the update cycle
  pft_pkg::req_t    req_r;
  logic             hit_r;
  logic [FW-1:0]    hit_idx_r;
  logic             any_inv_r;
  logic [FW-1:0]    inv_idx_r;
  logic             elig_r    [NUM_FRAMES];

  logic             hit_nxt;
  logic [FW-1:0]    hit_idx_nxt;
  logic             any_inv_nxt;
  logic [FW-1:0]    inv_idx_nxt;
  logic             elig_nxt  [NUM_FRAMES];

  logic [CW-1:0]    t_cnt [LV+1][NP];
  logic [FW-1:0]    t_idx [LV+1][NP];
  logic             t_ok  [LV+1][NP];
  logic             pick_hi;
  logic [FW-1:0]    victim;
  logic [FW-1:0]    slot;
  logic             wb;

  logic             out_strobe_r;
  logic [FW-1:0]    out_frame_r;
  logic [pft_pkg::OFF_W-1:0] out_offset_r;
  logic             out_hit_r;
  logic             out_wb_r;
  logic [PB-1:0]    out_ev_r;

  assign q_pop = (state_r == S_LOOK) & q_valid;

  // Lookup on the queue head: match, first empty frame, eviction candidates.
  always_comb begin
    hit_nxt     = 1'b0;
    hit_idx_nxt = '0;
    any_inv_nxt = 1'b0;
    inv_idx_nxt = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == q_data.page) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = FW'(i);
      end
      if (!valid_r[i]) begin
        any_inv_nxt = 1'b1;
        inv_idx_nxt = FW'(i);
      end
      elig_nxt[i] = valid_r[i] && (page_r[i] != last_r);
    end
  end

  // Tournament over eligible frames: highest count, ties to higher index.
  always_comb begin
    for (int j = 0; j < NP; j++) begin
      if (j < NUM_FRAMES) begin
        t_cnt[0][j] = cnt_r[j];
        t_idx[0][j] = FW'(j);
        t_ok[0][j]  = elig_r[j];
      end else begin
        t_cnt[0][j] = '0;
        t_idx[0][j] = '0;
        t_ok[0][j]  = 1'b0;
      end
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < NP; j++) begin
        t_cnt[l+1][j] = '0;
        t_idx[l+1][j] = '0;
        t_ok[l+1][j]  = 1'b0;
      end
      for (int j = 0; j < NP / 2; j++) begin
        if (j < (NP >> (l + 1))) begin
          pick_hi = t_ok[l][2*j+1] &&
                    (!t_ok[l][2*j] || t_cnt[l][2*j+1] >= t_cnt[l][2*j]);
          t_cnt[l+1][j] = pick_hi ? t_cnt[l][2*j+1] : t_cnt[l][2*j];
          t_idx[l+1][j] = pick_hi ? t_idx[l][2*j+1] : t_idx[l][2*j];
          t_ok[l+1][j]  = t_ok[l][2*j] | t_ok[l][2*j+1];
        end
      end
    end
    pick_hi = 1'b0;
    victim  = t_ok[LV][0] ? t_idx[LV][0] : '0;
  end

  always_comb begin
    priority if (hit_r) begin
      slot = hit_idx_r;
    end else if (any_inv_r) begin
      slot = inv_idx_r;
    end else begin
      slot = victim;
    end
    wb = ~hit_r & ~any_inv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOOK;
      out_strobe_r <= 1'b0;
      last_r       <= pft_pkg::LAST_INIT;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        cnt_r[i]   <= '0;
      end
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_LOOK: begin
          if (q_valid) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r      <= S_LOOK;
          out_strobe_r <= 1'b1;
          out_frame_r  <= slot;
          out_offset_r <= req_r.offset;
          out_hit_r    <= hit_r;
          out_wb_r     <= wb;
          out_ev_r     <= wb ? page_r[slot] : '0;
          if (hit_r) begin
            last_r <= req_r.page;
            if (cnt_r[slot] != pft_pkg::CNT_MAX) begin
              cnt_r[slot] <= cnt_r[slot] + CW'(1);
            end
          end else begin
            valid_r[slot] <= 1'b1;
            cnt_r[slot]   <= '0;
          end
        end
        default: state_r <= S_LOOK;
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r     <= q_data;
      hit_r     <= hit_nxt;
      hit_idx_r <= hit_idx_nxt;
      any_inv_r <= any_inv_nxt;
      inv_idx_r <= inv_idx_nxt;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        elig_r[i] <= elig_nxt[i];
      end
    end
    if (state_r == S_UPD) begin
      if (!hit_r) begin
        page_r[slot] <= req_r.page;
      end
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_frame        = out_frame_r;
  assign out_offset       = out_offset_r;
  assign out_hit          = out_hit_r;
  assign out_writeback    = out_wb_r;
  assign out_evicted_page = out_ev_r;

endmodule

/* hdl/page_frame_table_mfu_core.sv */
// Top level of the page frame table with most-frequently-used replacement.
// Depends on pft_pkg, pft_front, pft_queue and pft_back.
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------------------
//   request   start / busy         in_element_index
//   result    out_strobe (1 cyc)   out_frame, out_offset, out_hit,
//                                  out_writeback, out_evicted_page
//
// Flow: a request is taken when start is high and busy is low. The front
// stage registers the split page/offset and moves it into a two-entry queue.
// The back end works on each request in a lookup state and then an update
// state: the first compares the page against every frame and marks eviction
// candidates, the second picks the victim and updates the table. The back end
// pops no new request until the update of the last is done. On its way to the
// result a request passes the front register, the queue, the lookup registers
// and the result registers.
// Reset: rst_n is synchronous, active low; it empties the table (all frames
// invalid, counts zero), sets the last-accessed page to one, and drains the
// queue. Frame page tags are not cleared; they are read only once valid.
// Stalls: busy rises while the front register is full and the queue has no
// room. Results are shown for one cycle and cannot be held off.
module page_frame_table_mfu_core #(
  parameter int NUM_FRAMES = pft_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [pft_pkg::ELEM_W-1:0]         in_element_index,
  output logic                               out_strobe,
  output logic [$clog2(NUM_FRAMES)-1:0]      out_frame,
  output logic [pft_pkg::OFF_W-1:0]          out_offset,
  output logic                               out_hit,
  output logic                               out_writeback,
  output logic [pft_pkg::PAGE_BITS-1:0]      out_evicted_page
);

  // front to queue
  logic          fq_push;
  logic          fq_ready;
  pft_pkg::req_t fq_data;

  // queue to back end
  logic          qb_valid;
  logic          qb_pop;
  pft_pkg::req_t qb_data;

  // accept and classify requests
  pft_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element_index (in_element_index),
    .q_ready          (fq_ready),
    .q_push           (fq_push),
    .q_data           (fq_data)
  );

  // decouple front from table work
  pft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .ready     (fq_ready),
    .pop       (qb_pop),
    .valid     (qb_valid),
    .pop_data  (qb_data)
  );

  // look up, replace, report
  pft_back #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_data           (qb_data),
    .q_pop            (qb_pop),
    .out_strobe       (out_strobe),
    .out_frame        (out_frame),
    .out_offset       (out_offset),
    .out_hit          (out_hit),
    .out_writeback    (out_writeback),
    .out_evicted_page (out_evicted_page)
  );

endmodule
